// ===== hw/rtl/midi_track_note_pairing_parser_defines.svh =====
// Assertion macros for the MIDI track parser.
// Expects clk and arst_n in the scope of each use.
`ifndef MIDI_TRACK_NOTE_PAIRING_PARSER_DEFINES_SVH
`define MIDI_TRACK_NOTE_PAIRING_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define MTNP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MTNP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define MTNP_ASSERT(lbl, prop, msg)
`define MTNP_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/mtnp_pkg.sv =====
// Shared types and constants of the MIDI track parser.
// No dependencies.
package mtnp_pkg;
	localparam int STACK_DEPTH_DEF = 8;
	localparam int NSTACKS = 2048;
	localparam int EPOCH_W = 8;
	localparam logic [31:0] TRACK_MARK = 32'd1297379947;
	localparam logic [7:0] META_END = 8'h2F;
	localparam logic [7:0] META_TEMPO = 8'h51;

	localparam logic [2:0] KIND_NOTE = 3'd0;
	localparam logic [2:0] KIND_TEMPO = 3'd1;
	localparam logic [2:0] KIND_END = 3'd2;
	localparam logic [2:0] KIND_RESYNC = 3'd3;
	localparam logic [2:0] KIND_OVERFLOW = 3'd4;

	localparam logic [1:0] CFG_FILTER_EN = 2'd0;
	localparam logic [1:0] CFG_FLOOR = 2'd1;
	localparam logic [1:0] CFG_FIRST_TRACK = 2'd2;

	typedef struct packed {
		logic        valid;
		logic [2:0]  kind;
		logic [55:0] start_tick;
		logic [31:0] duration;
		logic [6:0]  key;
		logic [3:0]  ch;
		logic [15:0] track;
		logic [6:0]  vel;
	} note_rec_t;

	typedef struct packed {
		logic        valid;
		logic        push;
		logic [10:0] pos;
		logic [55:0] tick;
		logic [6:0]  vel;
		logic [15:0] track;
	} stack_req_t;
endpackage

// ===== hw/rtl/mtnp_stack.sv =====
// Note stacks: fill-count memory with epoch tags and the stack entry memory.
// Depends on mtnp_pkg and the assertion macro header.
`include "midi_track_note_pairing_parser_defines.svh"
module mtnp_stack #(
	parameter int STACK_DEPTH = mtnp_pkg::STACK_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mtnp_pkg::stack_req_t req,
	input  logic                 track_start,
	input  logic                 filter_en,
	input  logic [7:0]           vel_floor,
	output mtnp_pkg::note_rec_t  rsp,
	output logic                 busy
);
	import mtnp_pkg::*;

	localparam int FILL_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(NSTACKS * STACK_DEPTH);
	localparam int FENT_W = EPOCH_W + FILL_W;

	logic [FENT_W-1:0] fill_mem [NSTACKS];
	logic [62:0]       store_mem [NSTACKS * STACK_DEPTH];

	logic              op1_q, op2_q, clr_q;
	logic [10:0]       clr_cnt_q;
	logic [EPOCH_W-1:0] epoch_q;
	stack_req_t        req_s1, req_s2;
	logic [FENT_W-1:0] fill_rdata_q;
	logic [62:0]       store_rdata_q;

	logic              fill_we;
	logic [10:0]       fill_waddr;
	logic [FENT_W-1:0] fill_wdata;
	logic              store_we, store_re, pop_go;
	logic [ADDR_W-1:0] store_addr;
	logic [FILL_W-1:0] cnt, cnt_eff, cnt_idx;
	logic [6:0]        e_vel;
	logic [55:0]       e_tick;

	assign busy = clr_q | op1_q | op2_q;
	assign cnt = fill_rdata_q[FILL_W-1:0];
	assign cnt_eff = (fill_rdata_q[FENT_W-1:FILL_W] == epoch_q) ? cnt : '0;
	assign cnt_idx = req_s1.push ? cnt_eff : cnt_eff - FILL_W'(1);
	assign store_addr = ADDR_W'(req_s1.pos) * ADDR_W'(STACK_DEPTH) + ADDR_W'(cnt_idx);
	assign e_vel = store_rdata_q[62:56];
	assign e_tick = store_rdata_q[55:0];

	always_comb begin
		fill_we = 1'b0;
		fill_waddr = req_s1.pos;
		fill_wdata = '0;
		store_we = 1'b0;
		store_re = 1'b0;
		pop_go = 1'b0;
		rsp = '0;
		if (clr_q) begin
			fill_we = 1'b1;
			fill_waddr = clr_cnt_q;
		end else if (op1_q) begin
			if (req_s1.push) begin
				if (cnt_eff >= FILL_W'(STACK_DEPTH)) begin
					rsp.valid = 1'b1;
					rsp.kind = KIND_OVERFLOW;
					rsp.start_tick = req_s1.tick;
					rsp.key = req_s1.pos[6:0];
					rsp.ch = req_s1.pos[10:7];
					rsp.track = req_s1.track;
					rsp.vel = req_s1.vel;
				end else begin
					store_we = 1'b1;
					fill_we = 1'b1;
					fill_wdata = {epoch_q, cnt_eff + FILL_W'(1)};
				end
			end else if (cnt_eff != '0) begin
				store_re = 1'b1;
				pop_go = 1'b1;
				fill_we = 1'b1;
				fill_wdata = {epoch_q, cnt_idx};
			end
		end else if (op2_q) begin
			if (!(filter_en && ({1'b0, e_vel} < vel_floor))) begin
				rsp.valid = 1'b1;
				rsp.kind = KIND_NOTE;
				rsp.start_tick = e_tick;
				rsp.duration = 32'(req_s2.tick - e_tick);
				rsp.key = req_s2.pos[6:0];
				rsp.ch = req_s2.pos[10:7];
				rsp.track = req_s2.track;
				rsp.vel = e_vel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		if (req.valid) begin
			fill_rdata_q <= fill_mem[req.pos];
		end
		if (store_we) begin
			store_mem[store_addr] <= {req_s1.vel, req_s1.tick};
		end
		if (store_re) begin
			store_rdata_q <= store_mem[store_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			req_s1 <= req;
		end
		if (pop_go) begin
			req_s2 <= req_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op1_q <= 1'b0;
			op2_q <= 1'b0;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			epoch_q <= '0;
		end else begin
			op1_q <= req.valid;
			op2_q <= pop_go;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 11'd1;
				if (clr_cnt_q == 11'(NSTACKS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (track_start) begin
				if (epoch_q == '1) begin
					epoch_q <= '0;
					clr_q <= 1'b1;
					clr_cnt_q <= '0;
				end else begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
			end
		end
	end

	`MTNP_ASSERT(a_pop_order, op2_q |-> $past(op1_q), "store read without fill read")
	`MTNP_NEVER(a_fill_range, fill_we && !clr_q && (fill_wdata[FILL_W-1:0] > FILL_W'(STACK_DEPTH)), "fill count above depth")
	`MTNP_ASSERT(a_one_op, $onehot0({clr_q, op1_q, op2_q}), "overlapping stack operations")
endmodule

// ===== hw/rtl/midi_track_note_pairing_parser.sv =====
// Top level of the MIDI track parser with note pairing.
// Depends on mtnp_pkg, mtnp_stack and the assertion macro header.
//
//  channel  signals                               direction
//  input    in_valid/in_ready, data_byte          in
//  result   out_valid/out_ready, kind..velocity   out
//  config   cfg_we, cfg_index, cfg_data           in
//
// A byte is taken each cycle, except after note second bytes: a push holds
// the input for the fill read, a non-empty pop for the fill read, then the
// entry read (one memory port each), an empty pop for the fill read.
// After reset, and after every 256th track header, a pass over all 2048
// fill entries clears the fill memory; no byte is taken during it.
// A waiting result stalls input only while it is not taken.
`include "midi_track_note_pairing_parser_defines.svh"
module midi_track_note_pairing_parser #(
	parameter int STACK_DEPTH = mtnp_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [55:0] start_tick,
	output logic [31:0] duration,
	output logic [6:0]  note_key,
	output logic [3:0]  midi_channel,
	output logic [15:0] track_index,
	output logic [6:0]  note_velocity,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import mtnp_pkg::*;

	typedef enum logic [11:0] {
		PH_HUNT   = 12'b000000000001,
		PH_LEN    = 12'b000000000010,
		PH_DELTA  = 12'b000000000100,
		PH_STATUS = 12'b000000001000,
		PH_P1     = 12'b000000010000,
		PH_P2     = 12'b000000100000,
		PH_SYSLEN = 12'b000001000000,
		PH_SKIP   = 12'b000010000000,
		PH_MTYPE  = 12'b000100000000,
		PH_MLEN   = 12'b001000000000,
		PH_TEMPO  = 12'b010000000000,
		PH_RESYNC = 12'b100000000000
	} phase_t;

	phase_t      ph_q, ph_n;
	logic [7:0]  rs_q, rs_n, mt_q, mt_n;
	logic [6:0]  pk_q, pk_n;
	logic [55:0] tick_q, tick_n;
	logic [31:0] va_q, va_n, br_q, br_n, ta_q, ta_n, mw_q, mw_n;
	logic [15:0] trk_q, trk_n;
	logic        filt_q;
	logic [7:0]  floor_q;

	logic        accept, stk_busy, track_start, out_valid_q;
	note_rec_t   par_res, stk_rsp, out_q;
	stack_req_t  stk_req;
	logic [31:0] va_shift, br_dec;
	logic [7:0]  b;
	logic [3:0]  cls;

	assign accept = in_valid && in_ready;
	assign in_ready = !stk_busy && (!out_valid_q || out_ready);
	assign b = data_byte;
	assign cls = rs_q[7:4];
	assign va_shift = {va_q[24:0], b[6:0]};
	assign br_dec = (br_q != 32'd0) ? br_q - 32'd1 : 32'd0;

	always_comb begin
		ph_n = ph_q; rs_n = rs_q; mt_n = mt_q; pk_n = pk_q; tick_n = tick_q;
		va_n = va_q; br_n = br_q; ta_n = ta_q; mw_n = mw_q; trk_n = trk_q;
		track_start = 1'b0;
		par_res = '0;
		stk_req = '0;
		stk_req.pos = {rs_q[3:0], pk_q};
		stk_req.tick = tick_q;
		stk_req.vel = b[6:0];
		stk_req.track = trk_q;
		if (accept) begin
			case (ph_q)
				PH_HUNT: begin
					mw_n = {mw_q[23:0], b};
					if (mw_n == TRACK_MARK) begin
						track_start = 1'b1;
						rs_n = '0;
						tick_n = '0;
						br_n = 32'd4;
						ph_n = PH_LEN;
					end
				end
				PH_LEN, PH_SKIP: begin
					br_n = br_dec;
					if (br_dec == 32'd0) begin
						ph_n = PH_DELTA;
						va_n = '0;
					end
				end
				PH_DELTA: begin
					va_n = va_shift;
					if (!b[7]) begin
						tick_n = tick_q + 56'(va_shift);
						va_n = '0;
						ph_n = PH_STATUS;
					end
				end
				PH_STATUS: begin
					if (!b[7]) begin
						if (rs_q[7] && rs_q[7:4] != 4'hF) begin
							pk_n = b[6:0];
							if (cls == 4'hC || cls == 4'hD) begin
								ph_n = PH_DELTA;
								va_n = '0;
							end else begin
								ph_n = PH_P2;
							end
						end else begin
							ph_n = PH_RESYNC;
							mw_n = '0;
							par_res.valid = 1'b1;
							par_res.kind = KIND_RESYNC;
							par_res.start_tick = tick_q;
							par_res.track = trk_q;
						end
					end else if (b[7:4] != 4'hF) begin
						rs_n = b;
						ph_n = PH_P1;
					end else if (b <= 8'hF7) begin
						rs_n = '0;
						va_n = '0;
						ph_n = PH_SYSLEN;
					end else if (b == 8'hFF) begin
						rs_n = '0;
						ph_n = PH_MTYPE;
					end else begin
						ph_n = PH_RESYNC;
						mw_n = '0;
						par_res.valid = 1'b1;
						par_res.kind = KIND_RESYNC;
						par_res.start_tick = tick_q;
						par_res.track = trk_q;
					end
				end
				PH_P1: begin
					pk_n = b[6:0];
					if (cls == 4'hC || cls == 4'hD) begin
						ph_n = PH_DELTA;
						va_n = '0;
					end else begin
						ph_n = PH_P2;
					end
				end
				PH_P2: begin
					ph_n = PH_DELTA;
					va_n = '0;
					if (cls == 4'h8 || (cls == 4'h9 && b[6:0] == 7'd0)) begin
						stk_req.valid = 1'b1;
						stk_req.push = 1'b0;
					end else if (cls == 4'h9) begin
						stk_req.valid = 1'b1;
						stk_req.push = 1'b1;
					end
				end
				PH_SYSLEN: begin
					va_n = va_shift;
					if (!b[7]) begin
						br_n = va_shift;
						if (va_shift == 32'd0) begin
							ph_n = PH_DELTA;
							va_n = '0;
						end else begin
							ph_n = PH_SKIP;
						end
					end
				end
				PH_MTYPE: begin
					mt_n = b;
					va_n = '0;
					ph_n = PH_MLEN;
				end
				PH_MLEN: begin
					va_n = va_shift;
					if (!b[7]) begin
						br_n = va_shift;
						if (mt_q == META_END) begin
							trk_n = trk_q + 16'd1;
							ph_n = PH_HUNT;
							mw_n = '0;
							par_res.valid = 1'b1;
							par_res.kind = KIND_END;
							par_res.start_tick = tick_q;
							par_res.track = trk_q;
						end else if (mt_q == META_TEMPO) begin
							ta_n = '0;
							if (va_shift == 32'd0) begin
								ph_n = PH_DELTA;
								va_n = '0;
								par_res.valid = 1'b1;
								par_res.kind = KIND_TEMPO;
								par_res.start_tick = tick_q;
							end else begin
								ph_n = PH_TEMPO;
							end
						end else if (va_shift == 32'd0) begin
							ph_n = PH_DELTA;
							va_n = '0;
						end else begin
							ph_n = PH_SKIP;
						end
					end
				end
				PH_TEMPO: begin
					ta_n = {ta_q[23:0], b};
					br_n = br_dec;
					if (br_dec == 32'd0) begin
						ph_n = PH_DELTA;
						va_n = '0;
						par_res.valid = 1'b1;
						par_res.kind = KIND_TEMPO;
						par_res.start_tick = tick_q;
						par_res.duration = ta_n;
					end
				end
				PH_RESYNC: begin
					mw_n = {mw_q[23:0], b};
					if (mw_n[23:0] == 24'hFF2F00) begin
						trk_n = trk_q + 16'd1;
						ph_n = PH_HUNT;
						mw_n = '0;
					end
				end
				default: begin
					ph_n = PH_HUNT;
					mw_n = '0;
				end
			endcase
		end
		if (cfg_we && cfg_index == CFG_FIRST_TRACK) begin
			trk_n = cfg_data;
		end
	end

	mtnp_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (stk_req),
		.track_start (track_start),
		.filter_en   (filt_q),
		.vel_floor   (floor_q),
		.rsp         (stk_rsp),
		.busy        (stk_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_HUNT;
			rs_q <= '0; mt_q <= '0; pk_q <= '0; tick_q <= '0;
			va_q <= '0; br_q <= '0; ta_q <= '0; mw_q <= '0;
			trk_q <= 16'd2;
			filt_q <= 1'b0;
			floor_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ph_q <= ph_n;
			rs_q <= rs_n; mt_q <= mt_n; pk_q <= pk_n; tick_q <= tick_n;
			va_q <= va_n; br_q <= br_n; ta_q <= ta_n; mw_q <= mw_n;
			trk_q <= trk_n;
			if (cfg_we) begin
				case (cfg_index)
					CFG_FILTER_EN: filt_q <= cfg_data[0];
					CFG_FLOOR: floor_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (par_res.valid || stk_rsp.valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (par_res.valid) begin
			out_q <= par_res;
		end else if (stk_rsp.valid) begin
			out_q <= stk_rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = out_q.kind;
	assign start_tick = out_q.start_tick;
	assign duration = out_q.duration;
	assign note_key = out_q.key;
	assign midi_channel = out_q.ch;
	assign track_index = out_q.track;
	assign note_velocity = out_q.vel;

	`MTNP_NEVER(a_rsp_slot, stk_rsp.valid && out_valid_q, "stack result while output slot full")
	`MTNP_NEVER(a_rsp_clash, stk_rsp.valid && par_res.valid, "two results in one cycle")
	`MTNP_ASSERT(a_req_accept, stk_req.valid |-> accept && !stk_busy, "stack request without transfer")
endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for midi_track_note_pairing_parser: directed files, then random tracks.
// Depends on mtnp_pkg and the parser RTL; keeps its own copy of the parser and note stacks.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mtnp_pkg::*;

	localparam int DEPTH = STACK_DEPTH_DEF;
	localparam int STALL_LIMIT = 30000;
	localparam int SETTLE = 2100;

	typedef enum {
		SEEK_MARK, CHUNK_LEN, DELTA, STATUS, DATA1, DATA2, SYSEX_LEN,
		SKIP, META_TYPE, META_LEN, TEMPO_BYTES, RESYNC
	} phase_t;

	typedef struct {
		logic [2:0]  kind;
		logic [55:0] tick;
		logic [31:0] dur;
		logic [6:0]  key;
		logic [3:0]  ch;
		logic [15:0] trk;
		logic [6:0]  vel;
	} event_t;

	logic        clk = 0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  kind;
	logic [55:0] start_tick;
	logic [31:0] duration;
	logic [6:0]  note_key;
	logic [3:0]  midi_channel;
	logic [15:0] track_index;
	logic [6:0]  note_velocity;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	midi_track_note_pairing_parser dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// parser state mirror
	phase_t      phase;
	logic [63:0] tick_now;
	logic [31:0] vacc, remain, tempo_val, window;
	logic [7:0]  rstat, pkey, mkind;
	logic [15:0] trk_no;
	logic        filt_en;
	logic [7:0]  floor_v;
	int          fill [NSTACKS];
	logic [62:0] slot [NSTACKS*DEPTH];

	event_t      events_due [$];
	logic [7:0]  stream [$];
	int          errors;
	int          bytes_sent;
	bit          calm;
	int          stall;
	int          quiet;

	task automatic emit(input logic [2:0] k, input logic [55:0] t, input logic [31:0] d,
			input logic [6:0] key, input logic [3:0] ch, input logic [15:0] trk,
			input logic [6:0] vel);
		event_t e;
		e = '{k, t, d, key, ch, trk, vel};
		events_due.insert(events_due.size(), e);
	endtask

	task automatic to_delta();
		phase = DELTA;
		vacc = 0;
	endtask

	task automatic to_seek();
		phase = SEEK_MARK;
		window = 0;
	endtask

	task automatic pop_note(input int pos, input logic [3:0] ch, input logic [6:0] key);
		logic [62:0] e;
		if (fill[pos] == 0)
			return;
		fill[pos]--;
		e = slot[pos*DEPTH + fill[pos]];
		if (filt_en && {1'b0, e[62:56]} < floor_v)
			return;
		emit(KIND_NOTE, e[55:0], tick_now[31:0] - e[31:0], key, ch, trk_no, e[62:56]);
	endtask

	task automatic take_first(input logic [7:0] b);
		pkey = b;
		if (rstat[7:4] == 4'hC || rstat[7:4] == 4'hD)
			to_delta();
		else
			phase = DATA2;
	endtask

	task automatic take_second(input logic [7:0] b);
		logic [3:0] ch;
		logic [6:0] key;
		int pos;
		ch = rstat[3:0];
		key = pkey[6:0];
		pos = {ch, key};
		to_delta();
		if (rstat[7:4] == 4'h8) begin
			pop_note(pos, ch, key);
		end else if (rstat[7:4] == 4'h9) begin
			if (b[6:0] == 0) begin
				pop_note(pos, ch, key);
			end else if (fill[pos] >= DEPTH) begin
				emit(KIND_OVERFLOW, tick_now[55:0], 0, key, ch, trk_no, b[6:0]);
			end else begin
				slot[pos*DEPTH + fill[pos]] = {b[6:0], tick_now[55:0]};
				fill[pos]++;
			end
		end
	endtask

	task automatic flag_invalid();
		phase = RESYNC;
		window = 0;
		emit(KIND_RESYNC, tick_now[55:0], 0, 0, 0, trk_no, 0);
	endtask

	task automatic parse_byte(input logic [7:0] b);
		case (phase)
		SEEK_MARK: begin
			window = {window[23:0], b};
			if (window == TRACK_MARK) begin
				foreach (fill[i]) fill[i] = 0;
				rstat = 0;
				tick_now = 0;
				remain = 4;
				phase = CHUNK_LEN;
			end
		end
		CHUNK_LEN, SKIP: begin
			if (remain > 0) remain--;
			if (remain == 0) to_delta();
		end
		DELTA: begin
			vacc = {vacc[24:0], b[6:0]};
			if (!b[7]) begin
				tick_now += vacc;
				vacc = 0;
				phase = STATUS;
			end
		end
		STATUS: begin
			if (!b[7]) begin
				if (rstat >= 8'h80 && rstat < 8'hF0) take_first(b);
				else flag_invalid();
			end else if (b < 8'hF0) begin
				rstat = b;
				phase = DATA1;
			end else if (b <= 8'hF7) begin
				rstat = 0;
				vacc = 0;
				phase = SYSEX_LEN;
			end else if (b == 8'hFF) begin
				rstat = 0;
				phase = META_TYPE;
			end else begin
				flag_invalid();
			end
		end
		DATA1: take_first(b);
		DATA2: take_second(b);
		SYSEX_LEN: begin
			vacc = {vacc[24:0], b[6:0]};
			if (!b[7]) begin
				remain = vacc;
				if (remain == 0) to_delta();
				else phase = SKIP;
			end
		end
		META_TYPE: begin
			mkind = b;
			vacc = 0;
			phase = META_LEN;
		end
		META_LEN: begin
			vacc = {vacc[24:0], b[6:0]};
			if (!b[7]) begin
				remain = vacc;
				if (mkind == META_END) begin
					emit(KIND_END, tick_now[55:0], 0, 0, 0, trk_no, 0);
					trk_no++;
					to_seek();
				end else if (mkind == META_TEMPO) begin
					tempo_val = 0;
					if (remain == 0) begin
						to_delta();
						emit(KIND_TEMPO, tick_now[55:0], 0, 0, 0, 0, 0);
					end else begin
						phase = TEMPO_BYTES;
					end
				end else if (remain == 0) begin
					to_delta();
				end else begin
					phase = SKIP;
				end
			end
		end
		TEMPO_BYTES: begin
			tempo_val = {tempo_val[23:0], b};
			if (remain > 0) remain--;
			if (remain == 0) begin
				to_delta();
				emit(KIND_TEMPO, tick_now[55:0], tempo_val, 0, 0, 0, 0);
			end
		end
		RESYNC: begin
			window = {window[23:0], b};
			if (window[23:0] == 24'hFF2F00) begin
				trk_no++;
				to_seek();
			end
		end
		default: to_seek();
		endcase
	endtask

	// ---- stimulus helpers ----
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		parse_byte(b);
		bytes_sent++;
	endtask

	task automatic play();
		foreach (stream[i]) send_byte(stream[i]);
		stream.delete();
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic settle();
		while (events_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_registers(input logic en, input logic [7:0] fl,
			input logic [15:0] first);
		cfg_we <= 1;
		cfg_index <= CFG_FILTER_EN;
		cfg_data <= {15'd0, en};
		@(posedge clk);
		filt_en = en;
		cfg_index <= CFG_FLOOR;
		cfg_data <= {8'd0, fl};
		@(posedge clk);
		floor_v = fl;
		cfg_index <= CFG_FIRST_TRACK;
		cfg_data <= first;
		@(posedge clk);
		trk_no = first;
		cfg_we <= 0;
	endtask

	task automatic add_byte(input int v);
		stream.insert(stream.size(), 8'(v));
	endtask

	task automatic push_vlq(input logic [31:0] v);
		logic [7:0] g [$];
		g.insert(g.size(), {1'b0, v[6:0]});
		v = v >> 7;
		while (v != 0) begin
			g.push_front({1'b1, v[6:0]});
			v = v >> 7;
		end
		foreach (g[i]) add_byte(g[i]);
	endtask

	task automatic push_header();
		add_byte("M");
		add_byte("T");
		add_byte("r");
		add_byte("k");
		repeat (4) add_byte($urandom_range(0, 255));
	endtask

	task automatic push_random_track(input int n);
		logic [7:0] rs;
		logic [3:0] ch;
		int r, len;
		rs = 0;
		push_header();
		repeat (n) begin
			push_vlq(($urandom_range(0, 24) == 0) ? $urandom : $urandom_range(0, 40));
			r = $urandom_range(0, 99);
			ch = 4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
				: $urandom_range(0, 1));
			if (r < 70) begin
				if (r < 40)
					rs = {4'h9, ch};
				else
					rs = {$urandom_range(0, 1) ? 4'h8 : 4'h9, ch};
				if (stream.size() == 0 || $urandom_range(0, 2) != 0 || rs != stream[$])
					add_byte(rs);
				add_byte(($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
					: $urandom_range(60, 61));
				if (r < 40) add_byte($urandom_range(1, 127));
				else if (rs[7:4] == 4'h9) add_byte(0);
				else add_byte($urandom_range(0, 127));
			end else if (r < 76) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 3;
				add_byte(8'hFF);
				add_byte(META_TEMPO);
				push_vlq(len);
				repeat (len) add_byte($urandom_range(0, 255));
				rs = 0;
			end else if (r < 82) begin
				len = $urandom_range(0, 6);
				add_byte(8'hFF);
				add_byte($urandom_range(0, 1) ? $urandom_range(0, 8'h2E)
					: $urandom_range(8'h52, 8'hFF));
				push_vlq(len);
				repeat (len) add_byte($urandom_range(0, 255));
				rs = 0;
			end else if (r < 88) begin
				len = $urandom_range(0, 6);
				add_byte($urandom_range(0, 1) ? 8'hF0 : $urandom_range(8'hF1, 8'hF7));
				push_vlq(len);
				repeat (len) add_byte($urandom_range(0, 255));
				rs = 0;
			end else begin
				rs = {4'($urandom_range(8'hA, 8'hE)), ch};
				add_byte(rs);
				add_byte($urandom_range(0, 127));
				if (rs[7:4] != 4'hC && rs[7:4] != 4'hD)
					add_byte($urandom_range(0, 127));
			end
		end
		push_vlq($urandom_range(0, 3));
		r = $urandom_range(0, 9);
		if (r < 7) begin
			add_byte(8'hFF);
			add_byte(META_END);
			add_byte(r == 0 ? 8'h01 : 8'h00);
		end else begin
			if (r == 9 && rs == 0) add_byte($urandom_range(0, 127));
			else add_byte($urandom_range(8'hF8, 8'hFE));
			repeat ($urandom_range(0, 6)) add_byte($urandom_range(0, 255));
			add_byte(8'hFF);
			add_byte(META_END);
			add_byte(8'h00);
		end
		repeat ($urandom_range(0, 4)) add_byte($urandom_range(0, 255));
	endtask

	// ---- tests ----
	task automatic test_note_and_tempo();
		push_header();
		stream = {stream, 8'h00, 8'h90, 8'h3C, 8'h40, 8'h05, 8'h80, 8'h3C, 8'h00,
			8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20,
			8'h00, 8'hFF, 8'h51, 8'h00, 8'h00, 8'hFF, 8'h2F, 8'h00};
		play();
	endtask

	task automatic test_stack_overflow();
		push_header();
		stream = {stream, 8'h00, 8'h9F, 8'h7F, 8'h7F};
		repeat (8) stream = {stream, 8'h81, 8'h00, 8'h7F, 8'h01};
		repeat (10) stream = {stream, 8'h00, 8'h7F, 8'h00};
		stream = {stream, 8'h00, 8'hFF, 8'h2F, 8'h00};
		play();
	endtask

	task automatic test_resync();
		push_header();
		stream = {stream, 8'h00, 8'h40, 8'h12, 8'hFF, 8'h2F, 8'h00};
		push_header();
		stream = {stream, 8'h7F, 8'hFE, 8'hFF, 8'h2F, 8'h00};
		play();
	endtask

	task automatic test_random_tracks(input int target);
		while (bytes_sent < target) begin
			calm = ($urandom_range(0, 3) == 0);
			push_random_track($urandom_range(2, 30));
			play();
		end
		calm = 0;
	endtask

	// ---- result checking and receiver stalls ----
	always @(posedge clk) begin
		event_t e;
		if (arst_n && out_valid && out_ready) begin
			if (events_due.size() == 0) begin
				$display("%0t: unexpected result kind=%0d tick=%0d", $time, kind, start_tick);
				errors++;
			end else begin
				e = events_due.pop_front();
				if (kind !== e.kind || start_tick !== e.tick || duration !== e.dur ||
						note_key !== e.key || midi_channel !== e.ch ||
						track_index !== e.trk || note_velocity !== e.vel) begin
					$display("%0t: expected kind=%0d tick=%0d dur=%0d key=%0d ch=%0d trk=%0d vel=%0d",
						$time, e.kind, e.tick, e.dur, e.key, e.ch, e.trk, e.vel);
					$display("%0t: actual   kind=%0d tick=%0d dur=%0d key=%0d ch=%0d trk=%0d vel=%0d",
						$time, kind, start_tick, duration, note_key, midi_channel,
						track_index, note_velocity);
					errors++;
				end
			end
			stall = calm ? 0 : $urandom_range(0, 16);
		end else if (stall > 0) begin
			stall--;
		end
		out_ready <= (stall == 0);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		data_byte = 0;
		out_ready = 0;
		cfg_we = 0;
		cfg_index = CFG_FILTER_EN;
		cfg_data = 0;
		errors = 0;
		bytes_sent = 0;
		calm = 0;
		stall = 0;
		quiet = 0;
		filt_en = 0;
		floor_v = 0;
		trk_no = 2;
		rstat = 0;
		tick_now = 0;
		vacc = 0;
		remain = 0;
		tempo_val = 0;
		pkey = 0;
		mkind = 0;
		foreach (fill[i]) fill[i] = 0;
		to_seek();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_note_and_tempo();
		test_stack_overflow();
		test_resync();
		settle();
		set_registers(1, 8'd64, 16'd0);
		test_random_tracks(350);
		settle();
		set_registers(1, 8'd255, 16'hFFFF);
		test_note_and_tempo();
		test_random_tracks(650);
		settle();
		set_registers(1, 8'd0, 16'd1234);
		test_random_tracks(950);
		settle();
		set_registers(0, 8'd128, 16'd2);
		test_random_tracks(1250);
		settle();
		set_registers(1, 8'd100, 16'hFFFE);
		test_random_tracks(1550);

		while (events_due.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && events_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
